@@ hw/rtl/tccw_pkg.sv @@
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
package tccw_pkg;

    localparam logic [2:0] ACT_PUT    = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_SETCUR = 3'd2;
    localparam logic [2:0] ACT_SCROLL = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_DEF_FG  = 2'd2;
    localparam logic [1:0] CFG_DEF_BG  = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] ATTR_BLANK = 8'h0f;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_NL,
        OP_BS,
        OP_CHR,
        OP_CLEAR,
        OP_SETCUR,
        OP_SCROLL,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  ch;
        logic [7:0]  attr;
        logic        use_cursor;
        logic [10:0] position;
        logic        move;
        logic [7:0]  lines;
    } t_cmd;

    typedef struct packed {
        logic        scrolled;
        logic [7:0]  cell_attr;
        logic [7:0]  cell_char;
        logic [10:0] cursor;
    } t_res;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_DIV,
        ST_NL,
        ST_PUT,
        ST_MOVE,
        ST_SCR_SET,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_BLANK,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/tccw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hw/rtl/tccw_front.sv @@
// Front end: accepts words, decodes them into commands, two-entry queue.
`timescale 1ns / 1ps
module tccw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_word_valid,
    output logic                             o_word_ready,
    input  logic [tccw_pkg::IN_DATA_W-1:0]   i_word_data,
    input  logic [2:0]                       i_word_kind,
    input  logic [3:0]                       i_def_fg,
    input  logic [3:0]                       i_def_bg,
    output logic                             o_cmd_valid,
    output tccw_pkg::t_cmd                   o_cmd,
    input  logic                             i_cmd_ready
);
    import tccw_pkg::*;

    logic [7:0]  w_code;
    logic [3:0]  w_fg;
    logic [3:0]  w_bg;
    t_cmd        w_cmd;
    logic        w_push;
    logic        w_pop;

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign w_code = i_word_data[7:0];
    assign w_fg   = i_word_data[20] ? i_word_data[24:21] : i_def_fg;
    assign w_bg   = i_word_data[25] ? i_word_data[29:26] : i_def_bg;

    always_comb begin
        w_cmd            = '0;
        w_cmd.ch         = w_code;
        w_cmd.attr       = {w_bg, w_fg};
        w_cmd.use_cursor = i_word_data[8];
        w_cmd.position   = i_word_data[19:9];
        w_cmd.move       = i_word_data[30];
        w_cmd.lines      = i_word_data[38:31];
        case (i_word_kind)
            ACT_PUT: begin
                if (w_code == CH_NUL) begin
                    w_cmd.op = OP_NOP;
                end else if (w_code == CH_NL) begin
                    w_cmd.op = OP_NL;
                end else if (w_code == CH_BS) begin
                    w_cmd.op = OP_BS;
                end else begin
                    w_cmd.op = OP_CHR;
                    // tab is stored as a plain space
                    if (w_code == CH_TAB) w_cmd.ch = CH_SPACE;
                end
            end
            ACT_CLEAR: begin
                w_cmd.op   = OP_CLEAR;
                w_cmd.attr = {w_bg, 4'h0};
            end
            ACT_SETCUR: w_cmd.op = OP_SETCUR;
            ACT_SCROLL: w_cmd.op = OP_SCROLL;
            ACT_READ:   w_cmd.op = OP_READ;
            default:    w_cmd.op = OP_NOP;
        endcase
    end

    assign o_word_ready = (r_cnt != 2'd2);
    assign o_cmd_valid  = (r_cnt != 2'd0);
    assign o_cmd        = r_q[r_rp];
    assign w_push       = i_word_valid && o_word_ready;
    assign w_pop        = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule

@@ hw/rtl/tccw_back.sv @@
// Back end: sequencer that runs commands against the screen store.
`timescale 1ns / 1ps
module tccw_back #(
    parameter int MAX_CELLS = 2048,
    parameter int PW        = 12
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  tccw_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_columns,
    input  logic [7:0]      i_rows,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output tccw_pkg::t_res  o_res
);
    import tccw_pkg::*;

    localparam int AW  = $clog2(MAX_CELLS);
    localparam int SW  = ((PW > 16) ? PW : 16) + 1;
    localparam int BW  = $clog2(PW);
    localparam int CW  = $clog2(MAX_CELLS + 1) + 1;

    t_state          r_state, n_state;
    t_cmd            r_cmd,   n_cmd;
    logic [PW-1:0]   r_off,   n_off;
    logic [PW-1:0]   r_cursor, n_cursor;
    logic [PW-1:0]   r_idx,   n_idx;
    logic [PW-1:0]   r_end,   n_end;
    logic [PW-1:0]   r_start, n_start;
    logic [15:0]     r_shift, n_shift;
    logic [7:0]      r_rem,   n_rem;
    logic [BW-1:0]   r_bit,   n_bit;
    logic            r_scrolled, n_scrolled;
    logic [7:0]      r_rd_char, n_rd_char;
    logic [7:0]      r_rd_attr, n_rd_attr;
    logic            r_out_valid;
    t_res            r_out;
    logic [PW-1:0]   r_last;

    logic [7:0]      w_cols;
    logic [7:0]      w_rows;
    logic [15:0]     w_prod;
    logic [CW-1:0]   w_cells;
    logic [PW-1:0]   w_sel;
    logic [PW-1:0]   w_off_c;
    logic [PW-1:0]   w_pos;
    logic [PW-1:0]   w_pos_c;
    logic [PW-1:0]   w_cur_c;
    logic [8:0]      w_rem_sh;
    logic [PW-1:0]   w_bs_off;
    logic [SW-1:0]   w_src;
    logic [SW-1:0]   w_end_x;
    logic [SW-1:0]   w_shift_x;
    logic            w_out_free;

    logic            w_char_we, w_attr_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [7:0]      w_char_wd, w_attr_wd;
    logic [7:0]      w_char_rd, w_attr_rd;

    tccw_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_chars (
        .i_clk   (i_clk),
        .i_we    (w_char_we),
        .i_waddr (w_waddr),
        .i_wdata (w_char_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_char_rd)
    );

    tccw_ram #(.WIDTH(8), .DEPTH(MAX_CELLS)) u_attrs (
        .i_clk   (i_clk),
        .i_we    (w_attr_we),
        .i_waddr (w_waddr),
        .i_wdata (w_attr_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_attr_rd)
    );

    assign w_cols  = (i_columns == 8'd0) ? 8'd1 : i_columns;
    assign w_rows  = (i_rows == 8'd0) ? 8'd1 : i_rows;
    assign w_prod  = w_cols * w_rows;
    assign w_cells = (CW'(w_prod) > CW'(MAX_CELLS)) ? CW'(MAX_CELLS) : CW'(w_prod);

    // clamped put position, set-cursor/read position and cursor
    assign w_sel   = i_cmd.use_cursor ? r_cursor : w_pos;
    assign w_off_c = (w_sel > r_last) ? r_last : w_sel;
    assign w_pos   = PW'(i_cmd.position);
    assign w_pos_c = (w_pos > r_last) ? r_last : w_pos;
    assign w_cur_c = (r_cursor > r_last) ? r_last : r_cursor;

    // one remainder bit per cycle for the newline row start
    assign w_rem_sh  = {r_rem, r_off[r_bit]};
    assign w_bs_off  = (r_off == '0) ? '0 : r_off - PW'(1);
    assign w_src     = SW'(r_idx) + SW'(r_shift);
    assign w_end_x   = SW'(r_end);
    assign w_shift_x = SW'(r_shift);
    assign w_out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: if (r_idx == PW'(MAX_CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_NL:     n_state = ST_DIV;
                        OP_BS:     n_state = ST_PUT;
                        OP_CHR:    n_state = ST_PUT;
                        OP_CLEAR:  n_state = ST_CLEAR;
                        OP_SCROLL: n_state = ST_SCR_SET;
                        OP_READ:   n_state = ST_READ;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_DONE;
            ST_CLEAR: if (r_idx == r_last) n_state = ST_DONE;
            ST_DIV:   if (r_bit == '0) n_state = ST_NL;
            ST_NL:    n_state = ST_MOVE;
            ST_PUT:   n_state = ST_MOVE;
            ST_MOVE: begin
                if (r_cmd.move && (r_off > r_last)) n_state = ST_SCR_SET;
                else n_state = ST_DONE;
            end
            ST_SCR_SET: n_state = ST_COPY_RD;
            ST_COPY_RD: begin
                if (r_idx == r_start) n_state = ST_BLANK;
                else if (w_src < SW'(MAX_CELLS)) n_state = ST_COPY_WR;
            end
            ST_COPY_WR: n_state = ST_COPY_RD;
            ST_BLANK:   if ((r_idx > r_end) || (r_idx > r_last)) n_state = ST_DONE;
            ST_DONE:    if (w_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_off      = r_off;
        n_cursor   = r_cursor;
        n_idx      = r_idx;
        n_end      = r_end;
        n_start    = r_start;
        n_shift    = r_shift;
        n_rem      = r_rem;
        n_bit      = r_bit;
        n_scrolled = r_scrolled;
        n_rd_char  = r_rd_char;
        n_rd_attr  = r_rd_attr;
        o_cmd_ready = 1'b0;
        w_char_we  = 1'b0;
        w_attr_we  = 1'b0;
        w_waddr    = r_idx[AW-1:0];
        w_raddr    = w_pos_c[AW-1:0];
        w_char_wd  = CH_SPACE;
        w_attr_wd  = ATTR_BLANK;
        case (r_state)
            ST_INIT: begin
                w_char_we = 1'b1;
                w_attr_we = 1'b1;
                w_char_wd = '0;
                w_attr_wd = '0;
                n_idx     = r_idx + PW'(1);
            end
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_scrolled = 1'b0;
                    n_rd_char  = '0;
                    n_rd_attr  = '0;
                    n_off      = w_off_c;
                    n_idx      = '0;
                    n_rem      = '0;
                    n_bit      = BW'(PW - 1);
                    n_end      = w_cur_c;
                    n_shift    = w_cols * i_cmd.lines;
                    if (i_cmd.op == OP_SETCUR) n_cursor = w_pos_c;
                end
            end
            ST_READ: begin
                n_rd_char = w_char_rd;
                n_rd_attr = w_attr_rd;
            end
            ST_CLEAR: begin
                w_char_we = 1'b1;
                w_attr_we = 1'b1;
                w_attr_wd = r_cmd.attr;
                n_idx     = r_idx + PW'(1);
                n_cursor  = '0;
            end
            ST_DIV: begin
                n_rem = (w_rem_sh >= {1'b0, w_cols}) ? 8'(w_rem_sh - {1'b0, w_cols})
                                                      : w_rem_sh[7:0];
                n_bit = r_bit - BW'(1);
            end
            ST_NL: n_off = r_off + PW'(w_cols) - PW'(r_rem);
            ST_PUT: begin
                if (r_cmd.op == OP_BS) begin
                    w_char_we = 1'b1;
                    w_waddr   = w_bs_off[AW-1:0];
                    n_off     = w_bs_off;
                end else begin
                    w_char_we = 1'b1;
                    w_attr_we = 1'b1;
                    w_waddr   = r_off[AW-1:0];
                    w_char_wd = r_cmd.ch;
                    w_attr_wd = r_cmd.attr;
                    n_off     = r_off + PW'(1);
                end
            end
            ST_MOVE: begin
                if (r_cmd.move) n_cursor = r_off;
                n_end   = r_off;
                n_shift = 16'(w_cols);
            end
            ST_SCR_SET: begin
                n_scrolled = 1'b1;
                n_idx      = '0;
                if ((r_end < PW'(w_cols)) || (w_shift_x > w_end_x)) n_start = '0;
                else n_start = PW'(w_end_x - w_shift_x);
            end
            ST_COPY_RD: begin
                w_raddr = w_src[AW-1:0];
                if ((r_idx != r_start) && !(w_src < SW'(MAX_CELLS))) begin
                    n_idx = r_idx + PW'(1);
                end
            end
            ST_COPY_WR: begin
                w_char_we = 1'b1;
                w_attr_we = 1'b1;
                w_char_wd = w_char_rd;
                w_attr_wd = w_attr_rd;
                n_idx     = r_idx + PW'(1);
            end
            ST_BLANK: begin
                if ((r_idx > r_end) || (r_idx > r_last)) begin
                    n_cursor = r_start;
                end else begin
                    w_char_we = 1'b1;
                    w_attr_we = 1'b1;
                    n_idx     = r_idx + PW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_idx       <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cursor <= n_cursor;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cmd      <= n_cmd;
        r_off      <= n_off;
        r_end      <= n_end;
        r_start    <= n_start;
        r_shift    <= n_shift;
        r_rem      <= n_rem;
        r_bit      <= n_bit;
        r_scrolled <= n_scrolled;
        r_rd_char  <= n_rd_char;
        r_rd_attr  <= n_rd_attr;
        r_last     <= PW'(w_cells - CW'(1));
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out.cursor    <= r_cursor[10:0];
            r_out.cell_char <= r_rd_char;
            r_out.cell_attr <= r_rd_attr;
            r_out.scrolled  <= r_scrolled;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
endmodule

@@ hw/rtl/text_console_char_writer_unit.sv @@
// Text console writer: top level with configuration registers and stream ports.
// Work per word: a newline divides one position bit per step to find the row start; a clear
// writes every cell of the screen; a scroll copies each cell with a read and a write, then blanks the
// freed cells; a put or newline with move set that runs past the last cell also scrolls. One word in
// the sequencer at a time, and no new word is taken until the last is done; two-entry queue
// and output register decouple. Reset: synchronous; a clearing pass zeroes the store.
`timescale 1ns / 1ps
module text_console_char_writer_unit #(
    parameter int MAX_CELLS = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // code[7:0] use_cursor[8] position[19:9] fg_given[20] fg[24:21]
    // bg_given[25] bg[29:26] move[30] lines[38:31]
    input  logic [tccw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action[2:0]
    input  logic [2:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cursor[10:0] cell_char[18:11] cell_attr[26:19] scrolled[27]
    output logic [tccw_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import tccw_pkg::*;

    localparam int PW_RAW = $clog2(MAX_CELLS + 256) + 1;
    localparam int PW     = (PW_RAW > 12) ? PW_RAW : 12;

    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic [3:0] r_def_fg;
    logic [3:0] r_def_bg;

    logic       w_cmd_valid;
    logic       w_cmd_ready;
    t_cmd       w_cmd;
    t_res       w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'd80;
            r_rows    <= 8'd25;
            r_def_fg  <= 4'd7;
            r_def_bg  <= 4'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                CFG_DEF_FG:  r_def_fg  <= i_cfg_data[3:0];
                CFG_DEF_BG:  r_def_bg  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    tccw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (s_axis_tvalid),
        .o_word_ready (s_axis_tready),
        .i_word_data  (s_axis_tdata),
        .i_word_kind  (s_axis_tuser),
        .i_def_fg     (r_def_fg),
        .i_def_bg     (r_def_bg),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_ready  (w_cmd_ready)
    );

    tccw_back #(.MAX_CELLS(MAX_CELLS), .PW(PW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_columns   (r_columns),
        .i_rows      (r_rows),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (w_res)
    );

    assign m_axis_tdata = {4'b0, w_res};
endmodule
